/* rtl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared codes and the control word that travels along the cell chains.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam logic [2:0] MODE_SCAN   = 3'd0;
   localparam logic [2:0] MODE_REMOVE = 3'd1;
   localparam logic [2:0] MODE_INSERT = 3'd2;
   localparam logic [2:0] MODE_MERGE  = 3'd3;
   localparam logic [2:0] MODE_DONE   = 3'd4;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_OOM     = 3'd1;
   localparam logic [2:0] STATUS_NULL    = 3'd2;
   localparam logic [2:0] STATUS_UNKNOWN = 3'd3;
   localparam logic [2:0] STATUS_FULL    = 3'd4;

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   typedef struct packed {
      logic       vld;
      logic [2:0] mode;
      logic       hit;
      logic       full;
   } pkt_ctl_type;

endpackage

/* rtl/first_fit_heap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with a sorted, coalescing free-range table.
// ----------------------------------------------------------------------------
// One command is handled at a time. An allocate passes once along the chain of
// free-range cells; a free searches the live-block chain, edits the free chain
// and then closes the gap in the live chain. A null free or an allocate with the
// live table full goes straight to the response. The command token moves one
// cell a cycle, so the length of the cell chains sets how long a command takes.
module first_fit_heap_allocator import ffha_pkg::*; #(
   parameter int MAX_FREE_RANGES = 64,
   parameter int MAX_LIVE_BLOCKS = 64,
   parameter int HEADER_BYTES    = 24,
   parameter int ADDRESS_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [23:0] req_request_size,
   input  logic [31:0] req_block_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_address,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_free_ranges,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int AW  = ADDRESS_BITS;
   localparam int XW  = (AW > 32) ? AW : 32;
   localparam int W   = XW + 2;
   localparam int NF  = MAX_FREE_RANGES;
   localparam int NL  = MAX_LIVE_BLOCKS;
   localparam int FCW = $clog2(NF + 1);
   localparam int LCW = $clog2(NL + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LSCAN = 2'd1;
   localparam logic [1:0] S_FSCAN = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [31:0]    base_ff, base_in, limit_ff, limit_in;
   logic [AW-1:0]  top_ff, top_in;
   logic [FCW-1:0] fcount_ff, fcount_in;
   logic [LCW-1:0] lcount_ff, lcount_in;
   logic           is_free_ff, is_free_in, key_ok_ff, key_ok_in, commit_ff, commit_in;
   logic [W-1:0]   need_ff, need_in, sum;
   logic [AW-1:0]  addr_ff, addr_in, blk_ff, blk_in, flen_ff, flen_in;
   pkt_ctl_type    finj_ff, finj_in, linj_ff, linj_in;
   logic [31:0]    res_addr_ff, res_addr_in;
   logic [2:0]     res_status_ff, res_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_addr_ff, rsp_addr_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [6:0]     rsp_ranges_ff, rsp_ranges_in;
   logic           lwr_en;
   logic [AW-1:0]  lwr_start, lwr_len;

   pkt_ctl_type   fctl [NF+1];
   logic [AW-1:0] fa [NF+1];
   logic [AW-1:0] fb [NF+1];
   logic [AW-1:0] fstart [NF];
   logic [AW-1:0] flength [NF];
   pkt_ctl_type   lctl [NL+1];
   logic [AW-1:0] lb [NL+1];
   logic [AW-1:0] lstart [NL];
   logic [AW-1:0] llength [NL];

   assign fctl[0] = finj_ff;
   assign fa[0]   = '0;
   assign fb[0]   = '0;
   assign lctl[0] = linj_ff;
   assign lb[0]   = '0;

   for (genvar k = 0; k < NF; k++) begin : g_free
      logic [AW-1:0] n_start, n_len;
      if (k + 1 < NF) begin : g_nb
         assign n_start = fstart[k+1];
         assign n_len   = flength[k+1];
      end else begin : g_end
         assign n_start = '0;
         assign n_len   = '0;
      end
      ffha_free_cell #(
         .AW(AW), .W(W), .CW(FCW), .MAXR(NF), .HB(HEADER_BYTES), .IDX(k)
      ) u_cell (
         .clock(clock), .reset(reset), .is_free(is_free_ff), .need(need_ff),
         .blk(blk_ff), .flen(flen_ff), .count(fcount_ff),
         .nxt_start(n_start), .nxt_len(n_len),
         .pin_ctl(fctl[k]), .pin_a(fa[k]), .pin_b(fb[k]),
         .pout_ctl(fctl[k+1]), .pout_a(fa[k+1]), .pout_b(fb[k+1]),
         .ent_start(fstart[k]), .ent_len(flength[k])
      );
   end

   for (genvar k = 0; k < NL; k++) begin : g_live
      logic [AW-1:0] n_start, n_len;
      if (k + 1 < NL) begin : g_nb
         assign n_start = lstart[k+1];
         assign n_len   = llength[k+1];
      end else begin : g_end
         assign n_start = '0;
         assign n_len   = '0;
      end
      ffha_live_cell #(.AW(AW), .CW(LCW), .IDX(k)) u_cell (
         .clock(clock), .reset(reset), .count(lcount_ff), .key(addr_ff),
         .key_ok(key_ok_ff), .commit(commit_ff), .wr_en(lwr_en),
         .wr_start(lwr_start), .wr_len(lwr_len),
         .nxt_start(n_start), .nxt_len(n_len),
         .pin_ctl(lctl[k]), .pin_b(lb[k]),
         .pout_ctl(lctl[k+1]), .pout_b(lb[k+1]),
         .ent_start(lstart[k]), .ent_len(llength[k])
      );
   end

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      limit_in      = limit_ff;
      top_in        = top_ff;
      fcount_in     = fcount_ff;
      lcount_in     = lcount_ff;
      is_free_in    = is_free_ff;
      key_ok_in     = key_ok_ff;
      commit_in     = commit_ff;
      need_in       = need_ff;
      addr_in       = addr_ff;
      blk_in        = blk_ff;
      flen_in       = flen_ff;
      finj_in       = '0;
      linj_in       = '0;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ranges_in = rsp_ranges_ff;
      lwr_en        = 1'b0;
      lwr_start     = '0;
      lwr_len       = '0;
      sum           = W'(top_ff) + need_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               is_free_in  = req_command;
               need_in     = W'(req_request_size) + W'(HEADER_BYTES);
               addr_in     = AW'(req_block_address);
               key_ok_in   = (XW'(req_block_address) >> AW) == '0;
               blk_in      = AW'(req_block_address) - AW'(HEADER_BYTES);
               res_addr_in = '0;
               if (!req_command) begin
                  if (lcount_ff >= LCW'(NL)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = S_RESP;
                  end else begin
                     finj_in.vld  = 1'b1;
                     finj_in.mode = MODE_SCAN;
                     state_in     = S_FSCAN;
                  end
               end else if (req_block_address == '0) begin
                  res_status_in = STATUS_NULL;
                  state_in      = S_RESP;
               end else begin
                  linj_in.vld  = 1'b1;
                  linj_in.mode = MODE_SCAN;
                  commit_in    = 1'b0;
                  state_in     = S_LSCAN;
               end
            end
         end
         S_LSCAN: begin
            if (lctl[NL].vld) begin
               if (commit_ff) begin
                  lcount_in     = lcount_ff - LCW'(1);
                  res_status_in = STATUS_OK;
                  state_in      = S_RESP;
               end else if (!lctl[NL].hit) begin
                  res_status_in = STATUS_UNKNOWN;
                  state_in      = S_RESP;
               end else begin
                  flen_in      = lb[NL];
                  finj_in.vld  = 1'b1;
                  finj_in.mode = MODE_SCAN;
                  state_in     = S_FSCAN;
               end
            end
         end
         S_FSCAN: begin
            if (fctl[NF].vld) begin
               if (!is_free_ff) begin
                  state_in = S_RESP;
                  if (fctl[NF].hit) begin
                     if (fctl[NF].mode == MODE_REMOVE) begin
                        fcount_in = fcount_ff - FCW'(1);
                     end
                     lwr_en        = 1'b1;
                     lwr_start     = fa[NF];
                     lwr_len       = fb[NF];
                     lcount_in     = lcount_ff + LCW'(1);
                     res_addr_in   = 32'(fa[NF]);
                     res_status_in = STATUS_OK;
                  end else if (((sum >> AW) != '0) || (sum > W'(limit_ff))) begin
                     res_status_in = STATUS_OOM;
                  end else begin
                     top_in        = AW'(sum);
                     lwr_en        = 1'b1;
                     lwr_start     = top_ff + AW'(HEADER_BYTES);
                     lwr_len       = AW'(need_ff);
                     lcount_in     = lcount_ff + LCW'(1);
                     res_addr_in   = 32'(top_ff + AW'(HEADER_BYTES));
                     res_status_in = STATUS_OK;
                  end
               end else if (fctl[NF].full) begin
                  res_status_in = STATUS_FULL;
                  state_in      = S_RESP;
               end else begin
                  if (fctl[NF].mode == MODE_REMOVE) begin
                     fcount_in = fcount_ff - FCW'(1);
                  end else if (fctl[NF].mode == MODE_INSERT) begin
                     fcount_in = fcount_ff + FCW'(1);
                  end
                  // The range is back in the free table; now retire the live entry.
                  linj_in.vld  = 1'b1;
                  linj_in.mode = MODE_SCAN;
                  commit_in    = 1'b1;
                  state_in     = S_LSCAN;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_ranges_in = 7'(fcount_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            REG_HEAP_BASE: begin
               base_in = csr_data;
               if ((lcount_ff == '0) && (fcount_ff == '0)) begin
                  top_in = AW'(csr_data);
               end
            end
            REG_HEAP_LIMIT: begin
               limit_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         limit_ff     <= '1;
         top_ff       <= '0;
         fcount_ff    <= '0;
         lcount_ff    <= '0;
         finj_ff      <= '0;
         linj_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         top_ff       <= top_in;
         fcount_ff    <= fcount_in;
         lcount_ff    <= lcount_in;
         finj_ff      <= finj_in;
         linj_ff      <= linj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_free_ff    <= is_free_in;
      key_ok_ff     <= key_ok_in;
      commit_ff     <= commit_in;
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      blk_ff        <= blk_in;
      flen_ff       <= flen_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ranges_ff <= rsp_ranges_in;
   end

   assign req_stall          = state_ff != S_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_free_ranges    = rsp_ranges_ff;

endmodule

/* rtl/ffha_free_cell.sv */
// ----------------------------------------------------------------------------
// ffha_free_cell
// One entry of the address-sorted free table and one stage of its edit chain.
// ----------------------------------------------------------------------------
module ffha_free_cell import ffha_pkg::*; #(
   parameter int AW   = 32,
   parameter int W    = 34,
   parameter int CW   = 7,
   parameter int MAXR = 64,
   parameter int HB   = 24,
   parameter int IDX  = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          is_free,
   input  logic [W-1:0]  need,
   input  logic [AW-1:0] blk,
   input  logic [AW-1:0] flen,
   input  logic [CW-1:0] count,
   input  logic [AW-1:0] nxt_start,
   input  logic [AW-1:0] nxt_len,
   input  pkt_ctl_type   pin_ctl,
   input  logic [AW-1:0] pin_a,
   input  logic [AW-1:0] pin_b,
   output pkt_ctl_type   pout_ctl,
   output logic [AW-1:0] pout_a,
   output logic [AW-1:0] pout_b,
   output logic [AW-1:0] ent_start,
   output logic [AW-1:0] ent_len
);

   logic [AW-1:0] start_ff, start_in, len_ff, len_in;
   logic [AW-1:0] a_ff, a_in, b_ff, b_in;
   pkt_ctl_type   ctl_ff, ctl_in;
   logic          valid_k, has_next, fits, first0, atpos, mp, mn_here, mn_next, full;
   logic [W-1:0]  rem;

   always_comb begin
      valid_k  = count > CW'(IDX);
      has_next = count > CW'(IDX + 1);
      rem      = W'(len_ff) - need;
      fits     = valid_k && (W'(len_ff) >= need);
      first0   = (IDX == 0) && ((count == '0) || (start_ff > blk));
      atpos    = valid_k && (start_ff <= blk) && (!has_next || (nxt_start > blk));
      mp       = (start_ff + len_ff) == blk;
      mn_here  = valid_k && ((blk + flen) == start_ff);
      mn_next  = has_next && ((blk + flen) == nxt_start);
      full     = count >= CW'(MAXR);
      start_in = start_ff;
      len_in   = len_ff;
      ctl_in   = pin_ctl;
      a_in     = pin_a;
      b_in     = pin_b;
      if (pin_ctl.vld) begin
         unique case (pin_ctl.mode)
            MODE_SCAN: begin
               if (!is_free) begin
                  if (fits) begin
                     ctl_in.hit = 1'b1;
                     a_in       = start_ff + AW'(HB);
                     if (rem > W'(HB)) begin
                        start_in    = start_ff + AW'(need);
                        len_in      = AW'(rem);
                        b_in        = AW'(need);
                        ctl_in.mode = MODE_DONE;
                     end else begin
                        b_in        = len_ff;
                        start_in    = nxt_start;
                        len_in      = nxt_len;
                        ctl_in.mode = MODE_REMOVE;
                     end
                  end
               end else if (first0) begin
                  // The freed range goes in front of every held range.
                  if (mn_here) begin
                     start_in    = blk;
                     len_in      = len_ff + flen;
                     ctl_in.mode = MODE_DONE;
                  end else if (full) begin
                     ctl_in.full = 1'b1;
                     ctl_in.mode = MODE_DONE;
                  end else begin
                     start_in    = blk;
                     len_in      = flen;
                     a_in        = start_ff;
                     b_in        = len_ff;
                     ctl_in.mode = MODE_INSERT;
                  end
               end else if (atpos) begin
                  // This entry is the lower neighbour of the freed range.
                  if (mp && mn_next) begin
                     len_in      = len_ff + flen + nxt_len;
                     ctl_in.mode = MODE_REMOVE;
                  end else if (mp) begin
                     len_in      = len_ff + flen;
                     ctl_in.mode = MODE_DONE;
                  end else if (mn_next) begin
                     ctl_in.mode = MODE_MERGE;
                  end else if (full) begin
                     ctl_in.full = 1'b1;
                     ctl_in.mode = MODE_DONE;
                  end else begin
                     a_in        = blk;
                     b_in        = flen;
                     ctl_in.mode = MODE_INSERT;
                  end
               end
            end
            MODE_REMOVE: begin
               start_in = nxt_start;
               len_in   = nxt_len;
            end
            MODE_INSERT: begin
               start_in = pin_a;
               len_in   = pin_b;
               a_in     = start_ff;
               b_in     = len_ff;
            end
            MODE_MERGE: begin
               start_in    = blk;
               len_in      = len_ff + flen;
               ctl_in.mode = MODE_DONE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      if (pin_ctl.vld) begin
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

   assign pout_ctl  = ctl_ff;
   assign pout_a    = a_ff;
   assign pout_b    = b_ff;
   assign ent_start = start_ff;
   assign ent_len   = len_ff;

endmodule

/* rtl/ffha_live_cell.sv */
// ----------------------------------------------------------------------------
// ffha_live_cell
// One entry of the live-block table and one stage of its search chain.
// ----------------------------------------------------------------------------
module ffha_live_cell import ffha_pkg::*; #(
   parameter int AW  = 32,
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] count,
   input  logic [AW-1:0] key,
   input  logic          key_ok,
   input  logic          commit,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_start,
   input  logic [AW-1:0] wr_len,
   input  logic [AW-1:0] nxt_start,
   input  logic [AW-1:0] nxt_len,
   input  pkt_ctl_type   pin_ctl,
   input  logic [AW-1:0] pin_b,
   output pkt_ctl_type   pout_ctl,
   output logic [AW-1:0] pout_b,
   output logic [AW-1:0] ent_start,
   output logic [AW-1:0] ent_len
);

   logic [AW-1:0] start_ff, start_in, len_ff, len_in, b_ff, b_in;
   pkt_ctl_type   ctl_ff, ctl_in;
   logic          match;

   always_comb begin
      match    = (count > CW'(IDX)) && key_ok && (start_ff == key);
      start_in = start_ff;
      len_in   = len_ff;
      ctl_in   = pin_ctl;
      b_in     = pin_b;
      if (wr_en && (count == CW'(IDX))) begin
         start_in = wr_start;
         len_in   = wr_len;
      end
      if (pin_ctl.vld) begin
         unique case (pin_ctl.mode)
            MODE_SCAN: begin
               if (match) begin
                  ctl_in.hit = 1'b1;
                  b_in       = len_ff;
                  // Live addresses are unique, so closing the gap keeps lookups exact.
                  if (commit) begin
                     start_in    = nxt_start;
                     len_in      = nxt_len;
                     ctl_in.mode = MODE_REMOVE;
                  end else begin
                     ctl_in.mode = MODE_DONE;
                  end
               end
            end
            MODE_REMOVE: begin
               start_in = nxt_start;
               len_in   = nxt_len;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      b_ff     <= b_in;
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   assign pout_ctl  = ctl_ff;
   assign pout_b    = b_ff;
   assign ent_start = start_ff;
   assign ent_len   = len_ff;

endmodule

/* tb/first_fit_heap_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate and free commands through the allocator and checks every
// response against a cycle-free predictor of the free-range and live tables.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb import ffha_pkg::*;;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;
   localparam int   FREE_SLOTS = 64;
   localparam int   LIVE_SLOTS = 64;
   localparam int   HDR        = 24;
   localparam int   DRAIN_CYCLES = 300;
   localparam int   IDLE_LIMIT   = 5000;

   typedef struct {
      logic        cmd;
      logic [23:0] size;
      logic [31:0] addr;
   } heap_cmd_type;

   typedef struct {
      logic [31:0] addr;
      logic [2:0]  status;
      logic [6:0]  ranges;
   } heap_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_ALLOC;
   logic [23:0] req_request_size = '0;
   logic [31:0] req_block_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_address;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_free_ranges;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = REG_HEAP_BASE;
   logic [31:0] csr_data = '0;

   first_fit_heap_allocator u_top (.*);

   always #5 clock = ~clock;

   // Predictor state.
   logic [31:0] free_base [FREE_SLOTS];
   logic [31:0] free_len  [FREE_SLOTS];
   logic [31:0] live_addr [LIVE_SLOTS];
   logic [31:0] live_len  [LIVE_SLOTS];
   int          free_n = 0;
   int          live_n = 0;
   logic [31:0] heap_top = '0;
   logic [31:0] base_reg = '0;
   logic [31:0] limit_reg = 32'hFFFF_FFFF;
   logic [31:0] last_grant = '0;

   heap_cmd_type pend_q[$];
   heap_rsp_type rsp_expect_q[$];
   int           n_sent = 0;
   int           n_accepted = 0;
   int           errors = 0;
   int           idle_cycles = 0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
   endtask

   task automatic apply_command(input heap_cmd_type c, output heap_rsp_type r);
      logic [32:0] need;
      logic [32:0] top_end;
      logic [31:0] rem;
      logic [31:0] blk;
      logic [31:0] glen;
      logic [31:0] len;
      int          i;
      int          j;
      int          pos;
      bit          found;
      bit          mp;
      bit          mn;
      r.addr = '0;
      r.status = STATUS_OK;
      found = 0;
      if (c.cmd == CMD_ALLOC) begin
         need = 33'(c.size) + HDR;
         if (live_n >= LIVE_SLOTS) begin
            r.status = STATUS_FULL;
         end else begin
            for (i = 0; i < free_n; i++) begin
               if (33'(free_len[i]) >= need) begin
                  found = 1;
                  break;
               end
            end
            if (found) begin
               rem = free_len[i] - need[31:0];
               blk = free_base[i];
               if (rem > HDR) begin
                  free_base[i] = blk + need[31:0];
                  free_len[i] = rem;
                  glen = need[31:0];
               end else begin
                  glen = free_len[i];
                  for (j = i; j + 1 < free_n; j++) begin
                     free_base[j] = free_base[j+1];
                     free_len[j] = free_len[j+1];
                  end
                  free_n--;
               end
            end else begin
               // Covers both the address-space wrap and the limit.
               top_end = {1'b0, heap_top} + need;
               if (top_end > {1'b0, limit_reg}) begin
                  r.status = STATUS_OOM;
               end else begin
                  blk = heap_top;
                  heap_top = top_end[31:0];
                  glen = need[31:0];
               end
            end
            if (r.status == STATUS_OK) begin
               r.addr = blk + HDR;
               live_addr[live_n] = r.addr;
               live_len[live_n] = glen;
               live_n++;
            end
         end
         last_grant = r.addr;
      end else if (c.addr == '0) begin
         r.status = STATUS_NULL;
      end else begin
         for (j = 0; j < live_n; j++) begin
            if (live_addr[j] == c.addr) begin
               found = 1;
               break;
            end
         end
         if (!found) begin
            r.status = STATUS_UNKNOWN;
         end else begin
            blk = c.addr - HDR;
            len = live_len[j];
            for (pos = 0; pos < free_n; pos++) begin
               if (free_base[pos] > blk) break;
            end
            mp = pos > 0 && (free_base[pos-1] + free_len[pos-1]) == blk;
            mn = pos < free_n && (blk + len) == free_base[pos];
            if (!mp && !mn && free_n >= FREE_SLOTS) begin
               r.status = STATUS_FULL;
            end else begin
               live_n--;
               live_addr[j] = live_addr[live_n];
               live_len[j] = live_len[live_n];
               if (mp) begin
                  free_len[pos-1] = free_len[pos-1] + len;
                  if (mn) begin
                     free_len[pos-1] = free_len[pos-1] + free_len[pos];
                     for (i = pos; i + 1 < free_n; i++) begin
                        free_base[i] = free_base[i+1];
                        free_len[i] = free_len[i+1];
                     end
                     free_n--;
                  end
               end else if (mn) begin
                  free_base[pos] = blk;
                  free_len[pos] = free_len[pos] + len;
               end else begin
                  for (i = free_n; i > pos; i--) begin
                     free_base[i] = free_base[i-1];
                     free_len[i] = free_len[i-1];
                  end
                  free_base[pos] = blk;
                  free_len[pos] = len;
                  free_n++;
               end
            end
         end
      end
      r.ranges = 7'(free_n);
   endtask

   // Driver: presents queued items in bursts separated by random gaps.
   heap_cmd_type cur;
   heap_rsp_type pred;
   int           burst_left = 1;
   int           gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_command(cur, pred);
            rsp_expect_q.push_back(pred);
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pend_q.size() > 0) begin
               cur = pend_q.pop_front();
               req_command <= cur.cmd;
               req_request_size <= cur.size;
               req_block_address <= cur.addr;
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 10);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls on its own changing pattern and checks every response.
   heap_rsp_type want;
   int           stall_mode = 0;
   int           stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expect_q.size() == 0) begin
               report("unexpected response", rsp_result_address, '0);
            end else begin
               want = rsp_expect_q.pop_front();
               if (rsp_result_address !== want.addr)
                  report("result_address", rsp_result_address, want.addr);
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_free_ranges !== want.ranges)
                  report("free_ranges", 32'(rsp_free_ranges), 32'(want.ranges));
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 120);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_HEAP_BASE) begin
         base_reg = value;
         if (live_n == 0 && free_n == 0) heap_top = value;
      end else begin
         limit_reg = value;
      end
   endtask

   // Queues one item and waits until the block has taken it, so that the
   // next item can be chosen from the up-to-date live table.
   task automatic send(logic cmd, logic [23:0] size, logic [31:0] addr);
      heap_cmd_type c;
      c.cmd = cmd;
      c.size = size;
      c.addr = addr;
      pend_q.push_back(c);
      n_sent++;
      while (n_accepted != n_sent) @(posedge clock);
   endtask

   task automatic drain();
      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_items(int count, int alloc_pct);
      int          k;
      int          roll;
      logic [23:0] sz;
      logic [31:0] ad;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < alloc_pct) begin
            if (roll < 70) sz = 24'($urandom_range(0, 64));
            else if (roll < 90) sz = 24'($urandom_range(0, 4096));
            else sz = 24'($urandom);
            send(CMD_ALLOC, sz, $urandom);
         end else begin
            if (roll < 85 && live_n > 0) ad = live_addr[$urandom_range(0, live_n - 1)];
            else if (roll < 90) ad = '0;
            else if (roll < 95) ad = last_grant;
            else ad = $urandom;
            send(CMD_FREE, 24'($urandom), ad);
         end
      end
   endtask

   logic [31:0] a_blk;
   logic [31:0] b_blk;
   logic [31:0] c_blk;
   logic [31:0] d_blk;
   logic [31:0] e_blk;
   int          n;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_HEAP_BASE, 32'h0000_1000);
      write_reg(REG_HEAP_LIMIT, 32'h0000_1800);
      send(CMD_ALLOC, 24'd0, 32'hFFFF_FFFF);
      a_blk = last_grant;
      send(CMD_ALLOC, 24'd100, '0);
      b_blk = last_grant;
      send(CMD_ALLOC, 24'd8, '0);
      c_blk = last_grant;
      send(CMD_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_FREE, 24'hFF_FFFF, '0);
      send(CMD_FREE, '0, 32'hFFFF_FFFF);
      send(CMD_FREE, '0, a_blk);
      // A second free of the same block must be refused.
      send(CMD_FREE, '0, a_blk);
      send(CMD_FREE, '0, c_blk);
      // This one joins the ranges on both sides.
      send(CMD_FREE, '0, b_blk);
      send(CMD_ALLOC, 24'd0, '0);
      a_blk = last_grant;
      send(CMD_ALLOC, 24'd140, '0);
      d_blk = last_grant;
      // Leaves too little behind to split, so the whole range is granted.
      send(CMD_ALLOC, 24'd120, '0);
      e_blk = last_grant;
      send(CMD_FREE, '0, d_blk);
      send(CMD_FREE, '0, a_blk);
      send(CMD_FREE, '0, e_blk);
      send(CMD_ALLOC, 24'h00_07FF, '0);
      send(CMD_ALLOC, 24'd4000, '0);
      drain();

      write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
      for (n = 0; n < 70; n++) send(CMD_ALLOC, 24'($urandom_range(0, 48)), $urandom);
      random_items(200, 50);
      drain();

      write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
      write_reg(REG_HEAP_LIMIT, 32'h0000_0000);
      random_items(120, 55);
      drain();

      write_reg(REG_HEAP_BASE, 32'h0000_0000);
      write_reg(REG_HEAP_LIMIT, 32'h4000_0000);
      random_items(240, 55);
      drain();

      if (errors == 0 && rsp_expect_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
